FILE: hw/rtl/grille_mask_transform_reader_core_assert.svh
// Assertion macros used by the checker of the grille reader.
`ifndef GRILLE_MASK_TRANSFORM_READER_CORE_ASSERT_SVH
`define GRILLE_MASK_TRANSFORM_READER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GMTR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grille reader assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GMTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grille reader assertion failed");

`endif

FILE: hw/rtl/gmtr_pkg.sv
`timescale 1ns / 1ps
package gmtr_pkg;

  localparam int unsigned MaxSideDef = 8;
  localparam int unsigned CoordW     = 3;
  localparam int unsigned LetterW    = 8;
  localparam int unsigned GridW      = 4;
  localparam logic [GridW-1:0] GridSizeRst = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD_MASK = 2'd0,
    OP_LOAD_MSG  = 2'd1,
    OP_READ      = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    XF_NONE   = 3'd0,
    XF_ROT90  = 3'd1,
    XF_ROT180 = 3'd2,
    XF_ROT270 = 3'd3,
    XF_MIRROR = 3'd4
  } xform_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [CoordW-1:0]  row;
    logic [CoordW-1:0]  col;
    logic               hole_open;
    logic [LetterW-1:0] letter;
    logic [2:0]         transform;
  } in_item_t;

  typedef struct packed {
    logic [LetterW-1:0] out_letter;
    logic               last;
  } out_item_t;

  // Orientation as an element of the dihedral group: mirror first, then turns.
  typedef struct packed {
    logic       mirror;
    logic [1:0] turns;
  } orient_t;

  function automatic orient_t next_orient(orient_t cur, logic [2:0] xf);
    orient_t res;
    res = cur;
    case (xf)
      XF_ROT90, XF_ROT180, XF_ROT270: begin
        // A turn applied to a mirrored grille runs the other way.
        res.turns = cur.mirror ? (cur.turns - xf[1:0]) : (cur.turns + xf[1:0]);
      end
      XF_MIRROR: res.mirror = ~cur.mirror;
      default:   res = cur;
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/gmtr_ram.sv
`timescale 1ns / 1ps
module gmtr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read data holds while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/grille_mask_transform_reader_core.sv
`timescale 1ns / 1ps
// Turning grille reader. Mask cells and message cells are loaded one item at
// a time into two single-port-read memories. A read item first folds its
// transform (none, a clockwise turn of 90, 180 or 270 degrees, or a left-right
// mirror) into the stored orientation, then scans the n by n grid in row-major
// order, where n is grid_size capped at MaxSide. For each cell the message
// memory is read at the cell itself and the mask memory at the cell mapped
// back through the orientation, both in the same cycle. Every open hole yields
// one output item with the message letter, and the last of them carries last.
// A read holds the input side until its scan ends and the held-back item has
// been passed on, also while the output side stalls. One output item is held
// back so that last can be set on it once the scan ends; a read through a
// grille with no open holes produces nothing. Loads with row or col at or
// beyond n are dropped. grid_size is to be written through the configuration
// port only while the block is idle, which the block does not enforce. It
// resets to 8; the stored cells and orientation survive a change of grid size.
module grille_mask_transform_reader_core
  import gmtr_pkg::*;
#(
  parameter int unsigned MaxSide = MaxSideDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [GridW-1:0] cfg_wdata_i
);

  localparam int unsigned Cells = MaxSide * MaxSide;
  localparam int unsigned AddrW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam logic [GridW-1:0] MaxSideW = GridW'(MaxSide);

  // Cells are stored row-major with a fixed stride of MaxSide.
  function automatic logic [AddrW-1:0] cell_addr(logic [CoordW-1:0] r,
                                                 logic [CoordW-1:0] c);
    return AddrW'(32'(r) * MaxSide + 32'(c));
  endfunction

  // Configuration and orientation.
  logic [GridW-1:0] grid_q;
  orient_t          orient_q, orient_d;

  // Scan control.
  logic              scan_q, scan_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [CoordW-1:0] col_q, col_d;
  logic [CoordW-1:0] last_idx_q, last_idx_d;
  orient_t           scan_orient_q;

  // Memory read in flight, the held-back hit, and the output register.
  logic               rd_valid_q, rd_valid_d;
  logic               pend_valid_q, pend_valid_d;
  logic [LetterW-1:0] pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [GridW-1:0]   side;
  logic               in_accept;
  logic               in_range;
  logic               busy;
  logic               out_free;
  logic               hit;
  logic               consume;
  logic               issue;
  logic               push_mid;
  logic               push_final;
  logic               mask_we;
  logic               msg_we;
  logic [AddrW-1:0]   load_addr;
  logic [AddrW-1:0]   mask_raddr;
  logic [AddrW-1:0]   msg_raddr;
  logic [0:0]         mask_rdata;
  logic [LetterW-1:0] msg_rdata;
  logic [CoordW-1:0]  src_row;
  logic [CoordW-1:0]  src_col;
  logic [CoordW-1:0]  col_m;

  // A grid_size above MaxSide acts as MaxSide.
  assign side = (grid_q > MaxSideW) ? MaxSideW : grid_q;

  // The block takes no item while a read is still scanning or delivering.
  assign busy       = scan_q || rd_valid_q || pend_valid_q;
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_range  = ({1'b0, in_item_i.row} < side) && ({1'b0, in_item_i.col} < side);
  assign load_addr = cell_addr(in_item_i.row, in_item_i.col);
  assign mask_we   = in_accept && (in_item_i.operation == OP_LOAD_MASK) && in_range;
  assign msg_we    = in_accept && (in_item_i.operation == OP_LOAD_MSG) && in_range;

  // Map the scanned cell back to the stored mask cell: mirror, then turns.
  always_comb begin
    col_m = scan_orient_q.mirror ? (last_idx_q - col_q) : col_q;
    unique case (scan_orient_q.turns)
      2'd0: begin
        src_row = row_q;
        src_col = col_m;
      end
      2'd1: begin
        src_row = last_idx_q - col_m;
        src_col = row_q;
      end
      2'd2: begin
        src_row = last_idx_q - row_q;
        src_col = last_idx_q - col_m;
      end
      2'd3: begin
        src_row = col_m;
        src_col = last_idx_q - row_q;
      end
      default: begin
        src_row = row_q;
        src_col = col_m;
      end
    endcase
  end

  assign mask_raddr = cell_addr(src_row, src_col);
  assign msg_raddr  = cell_addr(row_q, col_q);

  // A returned cell is retired unless it is a hit that would push the held
  // item into a full output register.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hit        = mask_rdata[0];
  assign consume    = rd_valid_q && (!hit || !pend_valid_q || out_free);
  assign issue      = scan_q && (!rd_valid_q || consume);
  assign push_mid   = consume && hit && pend_valid_q;
  assign push_final = !scan_q && !rd_valid_q && pend_valid_q && out_free;

  always_comb begin
    orient_d   = orient_q;
    scan_d     = scan_q;
    row_d      = row_q;
    col_d      = col_q;
    last_idx_d = last_idx_q;

    if (in_accept && (in_item_i.operation == OP_READ)) begin
      orient_d   = next_orient(orient_q, in_item_i.transform);
      scan_d     = (side != '0);
      row_d      = '0;
      col_d      = '0;
      last_idx_d = CoordW'(side - GridW'(1));
    end else if (issue) begin
      if (col_q == last_idx_q) begin
        col_d = '0;
        if (row_q == last_idx_q) begin
          scan_d = 1'b0;
        end else begin
          row_d = row_q + CoordW'(1);
        end
      end else begin
        col_d = col_q + CoordW'(1);
      end
    end

    rd_valid_d = issue ? 1'b1 : (consume ? 1'b0 : rd_valid_q);

    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (consume && hit) begin
      pend_valid_d = 1'b1;
      pend_d       = msg_rdata;
    end else if (push_final) begin
      pend_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (push_mid) begin
      out_valid_d      = 1'b1;
      out_d.out_letter = pend_q;
      out_d.last       = 1'b0;
    end else if (push_final) begin
      out_valid_d      = 1'b1;
      out_d.out_letter = pend_q;
      out_d.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q       <= GridSizeRst;
      orient_q     <= '0;
      scan_q       <= 1'b0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        grid_q <= cfg_wdata_i;
      end
      orient_q     <= orient_d;
      scan_q       <= scan_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload and counters need no reset.
  always_ff @(posedge clk_i) begin
    row_q         <= row_d;
    col_q         <= col_d;
    last_idx_q    <= last_idx_d;
    scan_orient_q <= orient_d;
    pend_q        <= pend_d;
    out_q         <= out_d;
  end

  gmtr_ram #(
    .Width(1),
    .Depth(Cells)
  ) u_mask_ram (
    .clk_i  (clk_i),
    .we_i   (mask_we),
    .waddr_i(load_addr),
    .wdata_i(in_item_i.hole_open),
    .re_i   (issue),
    .raddr_i(mask_raddr),
    .rdata_o(mask_rdata)
  );

  gmtr_ram #(
    .Width(LetterW),
    .Depth(Cells)
  ) u_msg_ram (
    .clk_i  (clk_i),
    .we_i   (msg_we),
    .waddr_i(load_addr),
    .wdata_i(in_item_i.letter),
    .re_i   (issue),
    .raddr_i(msg_raddr),
    .rdata_o(msg_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hw/rtl/gmtr_checker.sv
`timescale 1ns / 1ps
`include "grille_mask_transform_reader_core_assert.svh"
module gmtr_checker
  import gmtr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input in_item_t         in_item_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_item_t        out_item_o,
  input logic             cfg_we_i
);

  logic in_accept;
  logic load_accept;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign load_accept = in_accept && (in_item_i.operation != OP_READ);

  // A stalled output item stays put.
  `GMTR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_item_o))

  // Output items are only produced while a read holds the input side.
  `GMTR_ASSERT_NOW(a_out_from_read, clk_i, rst_ni, $rose(out_valid_o),
                   $past(in_stall_o))

  // Loads and no-ops never make the block busy.
  `GMTR_ASSERT_NEXT(a_load_no_busy, clk_i, rst_ni, load_accept, !in_stall_o)

  // Configuration writes are to land only while the block is idle, which is not
  // enforced; such a write to an idle block starts no activity of its own.
  `GMTR_ASSERT_NEXT(a_cfg_quiet, clk_i, rst_ni,
                    cfg_we_i && !in_stall_o && !in_accept, !in_stall_o)

endmodule

bind grille_mask_transform_reader_core gmtr_checker u_gmtr_checker (.*);
